// ===== rtl/dual_motor_step_move_controller_top_assert.svh =====
// Assertion macros for the dual motor step move controller.
`ifndef DUAL_MOTOR_STEP_MOVE_CONTROLLER_TOP_ASSERT_SVH
`define DUAL_MOTOR_STEP_MOVE_CONTROLLER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define DMSMC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define DMSMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define DMSMC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define DMSMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/dmsmc_pkg.sv =====
// Shared types and constants of the dual motor step move controller.
`timescale 1ns / 1ps
`default_nettype none

package dmsmc_pkg;

	localparam int CountW = 31;
	localparam int DutyW  = 8;
	localparam int AddrW  = 3;

	localparam logic [CountW-1:0] COUNT_MAX      = 31'h7FFF_FFFF;
	localparam logic [DutyW-1:0]  FULL_DUTY      = 8'd255;
	localparam logic [DutyW-1:0]  RUN_DUTY_RESET = 8'd190;

	localparam logic [0:0] REG_RUN_DUTY = 1'b0;

	typedef enum logic [2:0] {
		OP_EDGE  = 3'd0,
		OP_SPIN  = 3'd1,
		OP_STOP  = 3'd2,
		OP_BRAKE = 3'd3,
		OP_MOVE  = 3'd4,
		OP_TICK  = 3'd5,
		OP_NOP   = 3'd6
	} op_t;

	typedef struct packed {
		op_t               op;
		logic              channel;
		logic [DutyW-1:0]  duty;
		logic              direction;
		logic [CountW-1:0] step_target;
	} cmd_t;

	typedef struct packed {
		logic [DutyW-1:0]  left_fwd_duty;
		logic [DutyW-1:0]  left_rev_duty;
		logic [DutyW-1:0]  right_fwd_duty;
		logic [DutyW-1:0]  right_rev_duty;
		logic              left_running;
		logic              right_running;
		logic              left_done;
		logic              right_done;
		logic [CountW-1:0] left_count;
		logic [CountW-1:0] right_count;
	} res_t;

	typedef struct packed {
		logic [DutyW-1:0]  fwd;
		logic [DutyW-1:0]  rev;
		logic              running;
		logic              dir;
		logic              done;
		logic [CountW-1:0] count;
		logic [CountW-1:0] target;
	} chan_state_t;

endpackage

`default_nettype wire

// ===== rtl/dual_motor_step_move_controller_top.sv =====
// Top level of the dual motor step move controller.
`timescale 1ns / 1ps
`default_nettype none

// Takes one event item per clock while the skid entry is free: encoder edge,
// spin, stop, brake, step move, control tick or no-op, and returns one result
// item per event holding the four bridge duties, the running and done flags
// and both edge counts as they stand after the event. Channel state updates
// in the cycle the item is accepted and its result enters a two-entry output
// buffer (result register plus skid entry), which lets the next item enter
// while an earlier result waits. run_duty is written through the APB port at
// address 0 and resets to 190.
module dual_motor_step_move_controller_top
	import dmsmc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	output logic                  cmd_ready,
	input  wire cmd_t             cmd,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output res_t                  res,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [31:0]      pwdata,
	output logic      [31:0]      prdata,
	output logic                  pready
);

	`include "dual_motor_step_move_controller_top_assert.svh"

	logic             accept;
	logic [DutyW-1:0] run_duty;
	chan_state_t      left_nxt;
	chan_state_t      right_nxt;
	res_t             res_nxt;
	logic             stop_left_acc;
	logic             left_off;

	assign accept = cmd_valid && cmd_ready;

	dmsmc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.run_duty (run_duty)
	);

	dmsmc_chan u_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (cmd),
		.chan_idx (1'b0),
		.run_duty (run_duty),
		.nxt      (left_nxt)
	);

	dmsmc_chan u_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (cmd),
		.chan_idx (1'b1),
		.run_duty (run_duty),
		.nxt      (right_nxt)
	);

	always_comb begin
		res_nxt.left_fwd_duty  = left_nxt.fwd;
		res_nxt.left_rev_duty  = left_nxt.rev;
		res_nxt.right_fwd_duty = right_nxt.fwd;
		res_nxt.right_rev_duty = right_nxt.rev;
		res_nxt.left_running   = left_nxt.running;
		res_nxt.right_running  = right_nxt.running;
		res_nxt.left_done      = left_nxt.done;
		res_nxt.right_done     = right_nxt.done;
		res_nxt.left_count     = left_nxt.count;
		res_nxt.right_count    = right_nxt.count;
	end

	dmsmc_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_data  (res_nxt),
		.push_ready (cmd_ready),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	assign stop_left_acc = accept && !res_valid && cmd.op == OP_STOP && !cmd.channel;
	assign left_off      = !res.left_running && res.left_fwd_duty == '0 &&
		res.left_rev_duty == '0;

	`DMSMC_ASSERT_SAME(a_full_buffer, clk, arst_n, !cmd_ready, res_valid, "skid full with result empty")
	`DMSMC_ASSERT_NEXT(a_accept_result, clk, arst_n, accept, res_valid, "accepted item left no result")
	`DMSMC_ASSERT_NEXT(a_stop_left, clk, arst_n, stop_left_acc, left_off, "left stop not reflected")

endmodule

`default_nettype wire

// ===== rtl/dmsmc_cfg.sv =====
// APB register block holding the run duty.
`timescale 1ns / 1ps
`default_nettype none

module dmsmc_cfg
	import dmsmc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [31:0]      pwdata,
	output logic      [31:0]      prdata,
	output logic                  pready,
	output logic      [DutyW-1:0] run_duty
);

	logic [DutyW-1:0] run_duty_q;
	logic             hit;

	assign hit    = (paddr[2] == REG_RUN_DUTY);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_duty_q <= RUN_DUTY_RESET;
		end else if (psel && penable && pwrite && pready && hit) begin
			run_duty_q <= pwdata[DutyW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = {{(32-DutyW){1'b0}}, run_duty_q};
		end
	end

	assign run_duty = run_duty_q;

endmodule

`default_nettype wire

// ===== rtl/dmsmc_chan.sv =====
// State and event handling of one motor channel.
`timescale 1ns / 1ps
`default_nettype none

module dmsmc_chan
	import dmsmc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire cmd_t             cmd,
	input  wire logic             chan_idx,
	input  wire logic [DutyW-1:0] run_duty,
	output chan_state_t           nxt
);

	chan_state_t cur_q;
	logic        addr;

	assign addr = (cmd.channel == chan_idx);

	always_comb begin
		nxt = cur_q;
		case (cmd.op)
			OP_EDGE: begin
				if (addr && cur_q.count != COUNT_MAX) begin
					nxt.count = CountW'(cur_q.count + 31'd1);
				end
			end
			OP_SPIN: begin
				if (addr) begin
					nxt.dir     = cmd.direction;
					nxt.running = 1'b1;
					nxt.fwd     = cmd.direction ? cmd.duty : '0;
					nxt.rev     = cmd.direction ? '0 : cmd.duty;
				end
			end
			OP_STOP: begin
				if (addr) begin
					nxt.running = 1'b0;
					nxt.fwd     = '0;
					nxt.rev     = '0;
				end
			end
			OP_BRAKE: begin
				nxt.fwd = FULL_DUTY;
				nxt.rev = FULL_DUTY;
			end
			OP_MOVE: begin
				if (addr) begin
					nxt.dir     = cmd.direction;
					nxt.running = 1'b1;
					nxt.done    = 1'b0;
					nxt.count   = '0;
					nxt.target  = cmd.step_target;
				end
			end
			OP_TICK: begin
				if (cur_q.running) begin
					if (cur_q.target <= cur_q.count) begin
						nxt.running = 1'b0;
						nxt.done    = 1'b1;
						nxt.fwd     = '0;
						nxt.rev     = '0;
					end else begin
						nxt.fwd = cur_q.dir ? run_duty : '0;
						nxt.rev = cur_q.dir ? '0 : run_duty;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (accept) begin
			cur_q <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dmsmc_obuf.sv =====
// Result register with a skid entry behind it.
`timescale 1ns / 1ps
`default_nettype none

module dmsmc_obuf
	import dmsmc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire res_t push_data,
	output logic      push_ready,
	output logic      res_valid,
	input  wire logic res_ready,
	output res_t      res
);

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_data_q;
	res_t skid_data_q;
	logic pop;

	assign pop        = out_valid_q && res_ready;
	assign push_ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
			if (push) begin
				skid_data_q <= push_data;
			end
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_data_q;

endmodule

`default_nettype wire

// ===== bench/dual_motor_step_move_controller_top_tb.sv =====
// Self-checking testbench for the dual motor step move controller top level.
`timescale 1ns / 1ps

module dual_motor_step_move_controller_top_tb;
	import dmsmc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT = 14;
	localparam int SPARE_REG = 1;
	localparam logic [AddrW-1:0] RUN_DUTY_ADDR = AddrW'(4 * int'(REG_RUN_DUTY));
	localparam logic [AddrW-1:0] SPARE_ADDR = AddrW'(4 * SPARE_REG);

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic res_valid;
	logic res_ready;
	res_t res;
	logic psel;
	logic penable;
	logic pwrite;
	logic [AddrW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	dual_motor_step_move_controller_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// motor state mirror
	logic [CountW-1:0] edge_cnt [2];
	logic [CountW-1:0] move_goal [2];
	logic running [2];
	logic fwd_dir [2];
	logic reached [2];
	logic [DutyW-1:0] bridge [4];
	logic [DutyW-1:0] duty_setting;

	cmd_t pending_cmds [$];
	res_t expected_outputs [$];
	bit cmd_fired;
	int idle_pct;
	int cycle_count;
	int errors;
	int queued_total;
	int checked_total;
	int moves_started;
	int targets_reached;
	int settings_used;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void set_drive(int ch, logic [DutyW-1:0] d, logic dir);
		fwd_dir[ch] = dir;
		running[ch] = 1'b1;
		bridge[2*ch] = dir ? d : '0;
		bridge[2*ch+1] = dir ? '0 : d;
	endfunction

	function automatic void halt_channel(int ch);
		running[ch] = 1'b0;
		bridge[2*ch] = '0;
		bridge[2*ch+1] = '0;
	endfunction

	function automatic res_t advance_motors(cmd_t c);
		res_t r;
		int ch;
		ch = int'(c.channel);
		case (c.op)
			OP_EDGE: begin
				if (edge_cnt[ch] != COUNT_MAX)
					edge_cnt[ch] = edge_cnt[ch] + 1'b1;
			end
			OP_SPIN: set_drive(ch, c.duty, c.direction);
			OP_STOP: halt_channel(ch);
			OP_BRAKE: begin
				for (int i = 0; i < 4; i++)
					bridge[i] = FULL_DUTY;
			end
			OP_MOVE: begin
				fwd_dir[ch] = c.direction;
				running[ch] = 1'b1;
				reached[ch] = 1'b0;
				edge_cnt[ch] = '0;
				move_goal[ch] = c.step_target;
				moves_started++;
			end
			OP_TICK: begin
				for (int i = 0; i < 2; i++) begin
					if (running[i]) begin
						if (move_goal[i] <= edge_cnt[i]) begin
							halt_channel(i);
							reached[i] = 1'b1;
							targets_reached++;
						end else begin
							set_drive(i, duty_setting, fwd_dir[i]);
						end
					end
				end
			end
			default: ;
		endcase
		r.left_fwd_duty = bridge[0];
		r.left_rev_duty = bridge[1];
		r.right_fwd_duty = bridge[2];
		r.right_rev_duty = bridge[3];
		r.left_running = running[0];
		r.right_running = running[1];
		r.left_done = reached[0];
		r.right_done = reached[1];
		r.left_count = edge_cnt[0];
		r.right_count = edge_cnt[1];
		return r;
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] seen);
		if (seen !== want) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			errors++;
		end
	endtask

	task automatic check_result(res_t got);
		res_t want;
		if (expected_outputs.size() == 0) begin
			$error("result item with no expectation pending");
			errors++;
		end else begin
			want = expected_outputs.pop_front();
			checked_total++;
			compare_field("left_fwd_duty", 32'(want.left_fwd_duty), 32'(got.left_fwd_duty));
			compare_field("left_rev_duty", 32'(want.left_rev_duty), 32'(got.left_rev_duty));
			compare_field("right_fwd_duty", 32'(want.right_fwd_duty),
				32'(got.right_fwd_duty));
			compare_field("right_rev_duty", 32'(want.right_rev_duty),
				32'(got.right_rev_duty));
			compare_field("left_running", 32'(want.left_running), 32'(got.left_running));
			compare_field("right_running", 32'(want.right_running), 32'(got.right_running));
			compare_field("left_done", 32'(want.left_done), 32'(got.left_done));
			compare_field("right_done", 32'(want.right_done), 32'(got.right_done));
			compare_field("left_count", 32'(want.left_count), 32'(got.left_count));
			compare_field("right_count", 32'(want.right_count), 32'(got.right_count));
		end
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			res_ready <= 1'b0;
		end else begin
			if (!cmd_valid || cmd_fired) begin
				if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					cmd <= pending_cmds.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
			res_ready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				cmd_fired = cmd_valid && cmd_ready;
				if (cmd_fired)
					expected_outputs.push_back(advance_motors(cmd));
				if (res_valid && res_ready)
					check_result(res);
			end
		end
	end

	task automatic apb_write(logic [AddrW-1:0] addr, logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == RUN_DUTY_ADDR) begin
			duty_setting = data[DutyW-1:0];
			settings_used++;
		end
	endtask

	task automatic apb_read_check(logic [AddrW-1:0] addr, logic [31:0] want);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			$error("prdata: expected %0d, got %0d", want, prdata);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic cmd_t cmd_of(op_t op);
		cmd_t c;
		c.op = op;
		c.channel = 1'($urandom_range(0, 1));
		c.duty = DutyW'($urandom_range(0, 255));
		c.direction = 1'($urandom_range(0, 1));
		c.step_target = CountW'($urandom);
		return c;
	endfunction

	function automatic logic [CountW-1:0] pick_target();
		int r;
		r = $urandom_range(0, 19);
		if (r < 15)
			return CountW'($urandom_range(0, 10));
		else if (r < 18)
			return CountW'($urandom);
		else
			return (r == 18) ? '0 : COUNT_MAX;
	endfunction

	task automatic enqueue(cmd_t c);
		pending_cmds.push_back(c);
		queued_total++;
	endtask

	task automatic enqueue_op(op_t op, logic ch, logic [DutyW-1:0] d, logic dir,
			logic [CountW-1:0] goal);
		cmd_t c;
		c = cmd_of(op);
		c.channel = ch;
		c.duty = d;
		c.direction = dir;
		c.step_target = goal;
		enqueue(c);
	endtask

	task automatic enqueue_follow_up(logic ch);
		cmd_t c;
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			c = cmd_of(OP_EDGE);
			c.channel = ch;
		end else if (r < 60) begin
			c = cmd_of(OP_EDGE);
			c.channel = !ch;
		end else if (r < 85) begin
			c = cmd_of(OP_TICK);
		end else if (r < 90) begin
			c = cmd_of(OP_MOVE);
			c.channel = !ch;
			c.step_target = pick_target();
		end else if (r < 95) begin
			c = cmd_of(OP_SPIN);
		end else begin
			c = cmd_of(op_t'($urandom_range(0, 7)));
		end
		enqueue(c);
	endtask

	task automatic queue_random_phase(int n);
		int stop_at;
		int kind;
		int steps;
		logic ch;
		cmd_t c;
		stop_at = queued_total + n;
		while (queued_total < stop_at) begin
			kind = $urandom_range(0, 9);
			ch = 1'($urandom_range(0, 1));
			if (kind < 6) begin
				c = cmd_of(OP_MOVE);
				c.channel = ch;
				c.step_target = pick_target();
				enqueue(c);
				steps = (c.step_target <= 10 ? int'(c.step_target) : 10) * 2
					+ $urandom_range(2, 8);
				repeat (steps) enqueue_follow_up(ch);
			end else if (kind < 8) begin
				c = cmd_of(OP_SPIN);
				c.channel = ch;
				enqueue(c);
				repeat ($urandom_range(2, 8)) enqueue_follow_up(ch);
			end else begin
				repeat ($urandom_range(1, 6)) enqueue(cmd_of(op_t'($urandom_range(0, 7))));
			end
		end
	endtask

	task automatic drain();
		while (pending_cmds.size() != 0 || cmd_valid || expected_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		cmd_t c;
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		res_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_pct = IDLE_PCT;
		cmd_fired = 1'b0;
		cycle_count = 0;
		errors = 0;
		queued_total = 0;
		checked_total = 0;
		moves_started = 0;
		targets_reached = 0;
		settings_used = 1;
		duty_setting = RUN_DUTY_RESET;
		for (int i = 0; i < 2; i++) begin
			edge_cnt[i] = '0;
			move_goal[i] = '0;
			running[i] = 1'b0;
			fwd_dir[i] = 1'b0;
			reached[i] = 1'b0;
		end
		for (int i = 0; i < 4; i++)
			bridge[i] = '0;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		apb_read_check(RUN_DUTY_ADDR, 32'(RUN_DUTY_RESET));

		enqueue(cmd_of(OP_NOP));
		c = cmd_of(OP_NOP);
		c.op = op_t'(3'd7);
		enqueue(c);
		enqueue_op(OP_EDGE, 1'b0, 8'd0, 1'b0, '0);
		enqueue_op(OP_EDGE, 1'b1, 8'd255, 1'b1, COUNT_MAX);
		enqueue_op(OP_SPIN, 1'b0, 8'd255, 1'b1, COUNT_MAX);
		enqueue_op(OP_SPIN, 1'b1, 8'd0, 1'b0, '0);
		enqueue_op(OP_SPIN, 1'b0, 8'd0, 1'b0, '0);
		enqueue_op(OP_SPIN, 1'b1, 8'd255, 1'b1, COUNT_MAX);
		// spin with stale target stops on the next tick
		enqueue_op(OP_TICK, 1'b0, 8'd0, 1'b0, '0);
		enqueue_op(OP_BRAKE, 1'b1, 8'd255, 1'b1, COUNT_MAX);
		enqueue_op(OP_TICK, 1'b1, 8'd255, 1'b1, COUNT_MAX);
		enqueue_op(OP_MOVE, 1'b0, 8'd0, 1'b1, CountW'(3));
		enqueue_op(OP_MOVE, 1'b1, 8'd255, 1'b0, COUNT_MAX);
		enqueue_op(OP_TICK, 1'b0, 8'd0, 1'b0, '0);
		repeat (3) enqueue_op(OP_EDGE, 1'b0, 8'd0, 1'b0, '0);
		enqueue_op(OP_TICK, 1'b0, 8'd0, 1'b0, '0);
		enqueue_op(OP_BRAKE, 1'b0, 8'd0, 1'b0, '0);
		enqueue_op(OP_TICK, 1'b0, 8'd0, 1'b0, '0);
		enqueue_op(OP_STOP, 1'b1, 8'd0, 1'b0, '0);
		enqueue_op(OP_STOP, 1'b0, 8'd255, 1'b1, COUNT_MAX);
		enqueue_op(OP_MOVE, 1'b0, 8'd255, 1'b1, '0);
		enqueue_op(OP_TICK, 1'b1, 8'd0, 1'b0, '0);
		enqueue_op(OP_SPIN, 1'b1, 8'd1, 1'b1, CountW'(5));
		drain();

		apb_write(RUN_DUTY_ADDR, 32'hA5A5_A5FF);
		apb_read_check(RUN_DUTY_ADDR, 32'd255);
		queue_random_phase(220);
		drain();

		apb_write(RUN_DUTY_ADDR, 32'h5A5A_5A00);
		apb_read_check(RUN_DUTY_ADDR, 32'd0);
		queue_random_phase(220);
		drain();

		apb_write(SPARE_ADDR, $urandom);
		apb_write(RUN_DUTY_ADDR, 32'($urandom_range(1, 254)));
		apb_read_check(RUN_DUTY_ADDR, 32'(duty_setting));
		idle_pct = 0;
		queue_random_phase(220);
		drain();
		idle_pct = IDLE_PCT;

		apb_write(RUN_DUTY_ADDR, 32'd1);
		queue_random_phase(220);
		drain();

		apb_write(RUN_DUTY_ADDR, 32'(RUN_DUTY_RESET));
		queue_random_phase(220);
		drain();

		$display("Checked %0d result items against %0d command items over %0d duty settings.",
			checked_total, queued_total, settings_used);
		$display("Step moves started: %0d, targets reached on a tick: %0d.",
			moves_started, targets_reached);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dmsmc_pkg.sv
rtl/dmsmc_cfg.sv
rtl/dmsmc_chan.sv
rtl/dmsmc_obuf.sv
rtl/dual_motor_step_move_controller_top.sv
bench/dual_motor_step_move_controller_top_tb.sv
